FILE: hdl/hvt_pkg.sv
// Shared types and constants for the histogram valley threshold block.
package hvt_pkg;

  localparam int PIX_W       = 8;
  localparam int GREY_LEVELS = 256;
  localparam int COUNT_W     = 21;
  localparam int TOL_W       = 21;
  localparam int THR_W       = 9;
  localparam int D1_W        = COUNT_W + 1;
  localparam int ALU_W       = COUNT_W + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(20);

  typedef logic signed [ALU_W-1:0] alu_word_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

  typedef struct packed {
    logic rd_en;
    logic clr_en;
  } hist_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;
  } pix_word_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             valley_found;
  } res_word_t;

endpackage

FILE: hdl/hvt_alu.sv
// Shared add/subtract unit with sign and zero flags.
module hvt_alu (
  input  hvt_pkg::alu_word_t  a,
  input  hvt_pkg::alu_word_t  b,
  input  hvt_pkg::alu_op_t    op,
  output hvt_pkg::alu_word_t  res,
  output hvt_pkg::alu_flags_t flags
);

  always_comb begin
    case (op)
      hvt_pkg::ALU_SUB: res = a - b;
      hvt_pkg::ALU_ADD: res = a + b;
      default:          res = a - b;
    endcase
  end

  assign flags.neg  = res[hvt_pkg::ALU_W-1];
  assign flags.zero = (res == '0);

endmodule

FILE: hdl/hvt_hist.sv
// Histogram bin memory with pixel increment pipeline and scan read/clear port.
module hvt_hist #(
  parameter int BIN_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_acc,
  input  logic [hvt_pkg::PIX_W-1:0]         pixel,
  input  hvt_pkg::hist_ctl_t                ctl,
  input  logic [$clog2(BIN_COUNT)-1:0]      addr,
  output logic [hvt_pkg::COUNT_W-1:0]       rd_data
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int PW = hvt_pkg::PIX_W + AW + 1;

  logic [hvt_pkg::COUNT_W-1:0] mem [BIN_COUNT];
  logic [hvt_pkg::COUNT_W-1:0] cnt_q;
  logic                        s1_valid;
  logic [AW-1:0]               s1_bin;
  logic                        fwd_valid;
  logic [AW-1:0]               fwd_addr;
  logic [hvt_pkg::COUNT_W-1:0] fwd_data;

  logic [PW-1:0]               bin_prod;
  logic [AW-1:0]               pix_bin;
  logic [AW-1:0]               rd_addr;
  logic                        rd_en;
  logic [hvt_pkg::COUNT_W-1:0] cur;
  logic [hvt_pkg::COUNT_W-1:0] inc;
  logic                        we;
  logic [AW-1:0]               wr_addr;
  logic [hvt_pkg::COUNT_W-1:0] wr_data;

  // bin = (pixel * BIN_COUNT) >> 8
  assign bin_prod = PW'(pixel) * PW'(BIN_COUNT);
  assign pix_bin  = bin_prod[hvt_pkg::PIX_W +: AW];

  assign rd_en   = pix_acc | ctl.rd_en;
  assign rd_addr = pix_acc ? pix_bin : addr;

  // take the count just written when the same bin is hit twice in a row
  assign cur = (fwd_valid && fwd_addr == s1_bin) ? fwd_data : cnt_q;
  assign inc = (cur == hvt_pkg::COUNT_MAX) ? cur : cur + 1'b1;

  assign we      = s1_valid | ctl.clr_en;
  assign wr_addr = s1_valid ? s1_bin : addr;
  assign wr_data = s1_valid ? inc : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_q <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= pix_acc;
      fwd_valid <= s1_valid;
    end
    s1_bin   <= pix_bin;
    fwd_addr <= s1_bin;
    fwd_data <= inc;
  end

  assign rd_data = cnt_q;

endmodule

FILE: hdl/hvt_seq.sv
// Scan sequencer: clear pass, flat spot search, peak tracking and valley pick.
module hvt_seq #(
  parameter int BIN_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hvt_pkg::TOL_W-1:0]     tol,
  output hvt_pkg::hist_ctl_t            hist_ctl,
  output logic [$clog2(BIN_COUNT)-1:0]  hist_addr,
  input  logic [hvt_pkg::COUNT_W-1:0]   hist_data,
  output hvt_pkg::alu_word_t            alu_a,
  output hvt_pkg::alu_word_t            alu_b,
  output hvt_pkg::alu_op_t              alu_op,
  input  hvt_pkg::alu_word_t            alu_res,
  input  hvt_pkg::alu_flags_t           alu_flags,
  input  logic                          res_free,
  output logic                          res_load,
  output logic                          res_found,
  output logic [$clog2(BIN_COUNT)-1:0]  res_bin,
  output logic                          busy
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int IW = $clog2(BIN_COUNT + 1);
  localparam int VW = BIN_COUNT - 2;
  localparam int CW = hvt_pkg::COUNT_W;
  localparam int DW = hvt_pkg::D1_W;

  typedef enum logic [11:0] {
    S_CLR   = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_FLUSH = 12'b0000_0000_0100,
    S_RD    = 12'b0000_0000_1000,
    S_D1    = 12'b0000_0001_0000,
    S_TOL   = 12'b0000_0010_0000,
    S_D2    = 12'b0000_0100_0000,
    S_PK1   = 12'b0000_1000_0000,
    S_PK2   = 12'b0001_0000_0000,
    S_ORDER = 12'b0010_0000_0000,
    S_VAL   = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t                 state, state_next;
  logic [IW-1:0]          k;
  logic [CW-1:0]          hw0, hw1, hw2;
  logic signed [DW-1:0]   d1w0, d1w1, d1w2;
  logic                   armed;
  logic                   have_best, have_second;
  logic [CW-1:0]          best_val, second_val;
  logic [AW-1:0]          best_bin, second_bin;
  logic [AW-1:0]          lo, hi;
  logic [VW-1:0]          vflag;
  logic [AW-1:0]          j;
  logic [AW-1:0]          dip_bin;
  logic                   found;

  logic [CW-1:0]          hin;
  logic signed [DW-1:0]   d1_new;
  logic                   eval_now;
  logic                   scan_done;
  state_t                 adv_state;
  logic [AW-1:0]          cur_bin;
  logic                   armed_now;
  logic                   alu_pos;
  logic                   both_peaks;

  assign hin       = (k == IW'(BIN_COUNT)) ? '0 : hist_data;
  assign d1_new    = (k >= IW'(2) && k <= IW'(BIN_COUNT - 1)) ? alu_res[DW-1:0] : '0;
  assign eval_now  = (k >= IW'(3));
  assign scan_done = (k == IW'(BIN_COUNT));
  assign adv_state = scan_done ? S_ORDER : S_RD;
  assign cur_bin   = AW'(k - IW'(2));
  assign armed_now = armed | (d1w1 != '0);
  assign alu_pos   = !alu_flags.neg && !alu_flags.zero;
  assign both_peaks = have_best && have_second;

  // memory port
  always_comb begin
    hist_ctl.rd_en  = 1'b0;
    hist_ctl.clr_en = 1'b0;
    hist_addr       = k[AW-1:0];
    case (state)
      S_CLR: begin
        hist_ctl.clr_en = 1'b1;
      end
      S_RD: begin
        hist_ctl.rd_en  = !scan_done;
        hist_ctl.clr_en = !scan_done;
      end
      default: begin
        hist_ctl.rd_en  = 1'b0;
      end
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = hvt_pkg::ALU_SUB;
    case (state)
      S_D1: begin
        alu_a = hvt_pkg::ALU_W'(hin);
        alu_b = hvt_pkg::ALU_W'(hw1);
      end
      S_TOL: begin
        // tol - |d1| without a separate negate
        alu_a  = hvt_pkg::ALU_W'(tol);
        alu_b  = hvt_pkg::ALU_W'(d1w1);
        alu_op = d1w1[DW-1] ? hvt_pkg::ALU_ADD : hvt_pkg::ALU_SUB;
      end
      S_D2: begin
        alu_a = hvt_pkg::ALU_W'(d1w2);
        alu_b = hvt_pkg::ALU_W'(d1w0);
      end
      S_PK1: begin
        alu_a = hvt_pkg::ALU_W'(best_val);
        alu_b = hvt_pkg::ALU_W'(hw0);
      end
      S_PK2: begin
        alu_a = hvt_pkg::ALU_W'(second_val);
        alu_b = hvt_pkg::ALU_W'(hw0);
      end
      S_ORDER: begin
        alu_a = hvt_pkg::ALU_W'(best_bin);
        alu_b = hvt_pkg::ALU_W'(second_bin);
      end
      default: begin
        alu_op = hvt_pkg::ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR:   state_next = (k == IW'(BIN_COUNT - 1)) ? S_IDLE : S_CLR;
      S_IDLE:  state_next = start ? S_FLUSH : S_IDLE;
      S_FLUSH: state_next = S_RD;
      S_RD:    state_next = S_D1;
      S_D1:    state_next = eval_now ? S_TOL : adv_state;
      S_TOL:   state_next = (armed_now && alu_pos) ? S_D2 : adv_state;
      S_D2: begin
        if (alu_flags.neg) begin
          state_next = S_PK1;
        end else begin
          state_next = adv_state;
        end
      end
      S_PK1: begin
        if (!have_best || alu_flags.neg) begin
          state_next = adv_state;
        end else begin
          state_next = S_PK2;
        end
      end
      S_PK2:   state_next = adv_state;
      S_ORDER: state_next = both_peaks ? S_VAL : S_OUT;
      S_VAL:   state_next = (j == AW'(BIN_COUNT - 2)) ? S_OUT : S_VAL;
      S_OUT:   state_next = res_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      k     <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLR: begin
          k <= (k == IW'(BIN_COUNT - 1)) ? '0 : k + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            k <= '0;
          end
        end
        S_D1: begin
          if (!eval_now && !scan_done) begin
            k <= k + 1'b1;
          end
        end
        S_TOL, S_D2, S_PK1, S_PK2: begin
          if (state_next == S_RD) begin
            k <= k + 1'b1;
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          armed       <= 1'b0;
          have_best   <= 1'b0;
          have_second <= 1'b0;
          found       <= 1'b0;
          hw0  <= '0;
          hw1  <= '0;
          hw2  <= '0;
          d1w0 <= '0;
          d1w1 <= '0;
          d1w2 <= '0;
        end
      end
      S_D1: begin
        // slide the count and first-difference windows by one bin
        hw0  <= hw1;
        hw1  <= hw2;
        hw2  <= hin;
        d1w0 <= d1w1;
        d1w1 <= d1w2;
        d1w2 <= d1_new;
        if (eval_now) begin
          vflag <= {vflag[VW-2:0], 1'b0};
        end
      end
      S_TOL: begin
        armed <= armed_now;
      end
      S_D2: begin
        if (alu_pos) begin
          vflag[0] <= 1'b1;
        end
      end
      S_PK1: begin
        if (!have_best || alu_flags.neg) begin
          if (have_best) begin
            have_second <= 1'b1;
            second_val  <= best_val;
            second_bin  <= best_bin;
          end
          have_best <= 1'b1;
          best_val  <= hw0;
          best_bin  <= cur_bin;
        end
      end
      S_PK2: begin
        if (!have_second || alu_flags.neg) begin
          have_second <= 1'b1;
          second_val  <= hw0;
          second_bin  <= cur_bin;
        end
      end
      S_ORDER: begin
        j <= AW'(1);
        if (alu_flags.neg) begin
          lo <= best_bin;
          hi <= second_bin;
        end else begin
          lo <= second_bin;
          hi <= best_bin;
        end
      end
      S_VAL: begin
        // oldest bin sits at the top of the flag shifter
        if (vflag[VW-1] && j > lo && j < hi) begin
          dip_bin <= j;
          found   <= 1'b1;
        end
        vflag <= {vflag[VW-2:0], 1'b0};
        j     <= j + 1'b1;
      end
      default: begin
        found <= found;
      end
    endcase
  end

  assign res_load  = (state == S_OUT) && res_free;
  assign res_found = found;
  assign res_bin   = dip_bin;
  assign busy      = (state != S_IDLE);

endmodule

FILE: hdl/histogram_valley_threshold.sv
// Top level of the histogram valley threshold block.
//
// Pixels come in on the pix channel (pix_valid / pix_stall / pix_data), one
// word per cycle while the block is idle. Each pixel bumps one of BIN_COUNT
// saturating 21-bit bin counts held in a single-port-write memory; a
// back-to-back hit on the same bin is forwarded around the memory.
// A word with last_pixel set closes the image: pix_stall rises and the
// sequencer scans the bins, loading each one and, as needed, passing it
// through the shared add/subtract unit for the first difference, the flat
// test, the curvature and the peak compares; it then walks the bins to
// pick the valley. The scan clears each bin as it reads it, so the next
// image starts from zero. The result word (threshold, valley_found) sits
// in an output register on the res channel; while res_stall holds it, the
// word stays put and the block still accepts the next image's pixels, but
// waits before loading a new result. flat_tolerance is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while idle, as the
// block itself does not enforce this. Reset (rst, synchronous) sets the
// tolerance to 20 and runs a clearing pass over every bin of the memory
// with pix_stall held high.
module histogram_valley_threshold #(
  parameter int BIN_COUNT = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  hvt_pkg::pix_word_t             pix_data,
  output logic                           res_valid,
  input  logic                           res_stall,
  output hvt_pkg::res_word_t             res_data,
  input  logic                           cfg_wr_en,
  input  logic [hvt_pkg::TOL_W-1:0]      cfg_wr_data
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int BW = hvt_pkg::GREY_LEVELS / BIN_COUNT;
  localparam int TW = hvt_pkg::THR_W + AW;

  logic [hvt_pkg::TOL_W-1:0]   flat_tolerance;
  logic                        busy;
  logic                        pix_acc;
  logic                        start;
  hvt_pkg::hist_ctl_t          hist_ctl;
  logic [AW-1:0]               hist_addr;
  logic [hvt_pkg::COUNT_W-1:0] hist_data;
  hvt_pkg::alu_word_t          alu_a, alu_b, alu_res;
  hvt_pkg::alu_op_t            alu_op;
  hvt_pkg::alu_flags_t         alu_flags;
  logic                        res_free;
  logic                        res_load;
  logic                        res_found;
  logic [AW-1:0]               res_bin;
  logic [TW-1:0]               thr_prod;

  // accept pixels only while idle
  assign pix_stall = busy;
  assign pix_acc   = pix_valid && !pix_stall;
  assign start     = pix_acc && pix_data.last_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_tolerance <= hvt_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      flat_tolerance <= cfg_wr_data;
    end
  end

  hvt_hist #(.BIN_COUNT(BIN_COUNT)) u_hist (
    .clk     (clk),
    .rst     (rst),
    .pix_acc (pix_acc),
    .pixel   (pix_data.pixel),
    .ctl     (hist_ctl),
    .addr    (hist_addr),
    .rd_data (hist_data)
  );

  hvt_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .op    (alu_op),
    .res   (alu_res),
    .flags (alu_flags)
  );

  hvt_seq #(.BIN_COUNT(BIN_COUNT)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .tol       (flat_tolerance),
    .hist_ctl  (hist_ctl),
    .hist_addr (hist_addr),
    .hist_data (hist_data),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_op    (alu_op),
    .alu_res   (alu_res),
    .alu_flags (alu_flags),
    .res_free  (res_free),
    .res_load  (res_load),
    .res_found (res_found),
    .res_bin   (res_bin),
    .busy      (busy)
  );

  // threshold = (valley bin + 1) * bin width; constant multiply
  assign thr_prod = (TW'(res_bin) + 1'b1) * TW'(BW);

  // output register: load when empty or being drained this cycle
  assign res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (res_load) begin
      res_data.valley_found <= res_found;
      res_data.threshold    <= res_found ? thr_prod[hvt_pkg::THR_W-1:0] : '0;
    end
  end

endmodule

FILE: hdl/hvt_chk.sv
// Port checker for the histogram valley threshold block, with its bind.
module hvt_chk (
  input logic               clk,
  input logic               rst,
  input logic               pix_valid,
  input logic               pix_stall,
  input hvt_pkg::pix_word_t pix_data,
  input logic               res_valid,
  input logic               res_stall,
  input hvt_pkg::res_word_t res_data
);

  // hold a stalled result word
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result word changed while stalled");

  // reset starts the clearing pass, so input is held off
  a_rst_stall: assert property (@(posedge clk)
    rst |=> pix_stall)
    else $error("pixel input open right after reset");

  // the last pixel of an image starts the scan
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && pix_data.last_pixel |=> pix_stall)
    else $error("input not held off after last pixel");

  // a new result only comes out of a scan
  a_res_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_stall))
    else $error("result raised without a scan");

  // the flag and a nonzero threshold go together
  a_flag_thr: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.valley_found == (res_data.threshold != '0)))
    else $error("valley flag and threshold disagree");

endmodule

bind histogram_valley_threshold hvt_chk u_hvt_chk (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .pix_data  (pix_data),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

FILE: bench/tb.sv
// Testbench for the histogram valley threshold block: streams grey images, predicts each threshold.
`timescale 1ns / 1ps

module tb;

  localparam int BINS          = 32;
  localparam int BIN_W         = hvt_pkg::GREY_LEVELS / BINS;
  localparam int RESET_CYCLES  = 8;
  // Settling time after a last pixel, with room for the scan to finish.
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_HOLD     = 3000;
  localparam int ITEM_TARGET   = 1000;
  localparam int PHASE_ITEMS   = 150;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RUN_REPS      = 40;
  localparam logic [hvt_pkg::TOL_W-1:0] TOL_MAX = {hvt_pkg::TOL_W{1'b1}};

  // One entry of the pixel queue: a word and how many times in a row to send it.
  typedef struct packed {
    hvt_pkg::pix_word_t word;
    logic [23:0]        reps;
  } pix_item_t;

  logic                      clk;
  logic                      rst;
  logic                      pix_valid;
  logic                      pix_stall;
  hvt_pkg::pix_word_t        pix_data;
  logic                      res_valid;
  logic                      res_stall;
  hvt_pkg::res_word_t        res_data;
  logic                      cfg_wr_en;
  logic [hvt_pkg::TOL_W-1:0] cfg_wr_data;

  pix_item_t          pix_pending [$];
  hvt_pkg::res_word_t thr_expected [$];

  // Shadow copy of the block's state: bin counts and the flat tolerance.
  logic [hvt_pkg::COUNT_W-1:0] bin_model [BINS];
  logic [hvt_pkg::TOL_W-1:0]   tol_model;

  int          cycle_count    = 0;
  int          mismatch_count = 0;
  bit          pix_took       = 1'b0;  // pixel word accepted at the last rising edge
  bit          res_took       = 1'b0;  // result word accepted at the last rising edge
  bit          quiet          = 1'b0;  // no idling on either side
  bit          hold_req       = 1'b0;  // ask the receiver for one long hold-off
  bit          driving        = 1'b0;  // the driver owns an item not yet fully sent
  pix_item_t   cur_item;
  int unsigned reps_left      = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;

  histogram_valley_threshold #(
    .BIN_COUNT(BINS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Work out the result of the image held in bin_model under tol_model.
  // slope is the central difference of the counts, curve the central
  // difference of slope; both are zero on the end bins.
  function automatic hvt_pkg::res_word_t predict_threshold();
    int                 slope [BINS];
    int                 curve [BINS];
    bit                 flat [BINS];
    bit                 armed;
    bit                 got_best;
    bit                 got_second;
    bit                 got_valley;
    int                 best_bin;
    int                 second_bin;
    int                 dip_bin;
    int                 lo;
    int                 hi;
    int                 mag;
    int unsigned        best_val;
    int unsigned        second_val;
    int unsigned        cnt;
    hvt_pkg::res_word_t r;
    armed      = 1'b0;
    got_best   = 1'b0;
    got_second = 1'b0;
    got_valley = 1'b0;
    best_bin   = 0;
    second_bin = 0;
    dip_bin    = 0;
    best_val   = 0;
    second_val = 0;
    foreach (slope[i]) begin
      slope[i] = 0;
      curve[i] = 0;
      flat[i]  = 1'b0;
    end
    for (int i = 1; i < BINS - 1; i++)
      slope[i] = int'(bin_model[i + 1]) - int'(bin_model[i - 1]);

    // Peak pass: the search arms on the first nonzero slope, current bin included.
    for (int i = 1; i < BINS - 1; i++) begin
      curve[i] = slope[i + 1] - slope[i - 1];
      mag      = (slope[i] < 0) ? -slope[i] : slope[i];
      if (slope[i] != 0) armed = 1'b1;
      flat[i] = armed && (mag < int'(tol_model));
      cnt     = bin_model[i];
      if (flat[i] && curve[i] < 0) begin
        if (!got_best || cnt > best_val) begin
          // demote the old best to second place
          if (got_best) begin
            got_second = 1'b1;
            second_bin = best_bin;
            second_val = best_val;
          end
          got_best = 1'b1;
          best_bin = i;
          best_val = cnt;
        end else if (!got_second || cnt > second_val) begin
          got_second = 1'b1;
          second_bin = i;
          second_val = cnt;
        end
      end
    end

    // Valley pass: keep the last valley strictly between the two peaks.
    lo = (best_bin < second_bin) ? best_bin : second_bin;
    hi = (best_bin < second_bin) ? second_bin : best_bin;
    for (int i = 1; i < BINS - 1; i++) begin
      if (flat[i] && curve[i] > 0 && i > lo && i < hi) begin
        got_valley = 1'b1;
        dip_bin    = i;
      end
    end

    r.valley_found = got_best && got_second && got_valley;
    r.threshold    = r.valley_found ? hvt_pkg::THR_W'((dip_bin + 1) * BIN_W) : '0;
    return r;
  endfunction

  // Sample both channels and the register port at the rising edge; advance
  // the shadow state on every accepted pixel and check every accepted result.
  always @(posedge clk) begin : model_and_check
    int                 bin_idx;
    hvt_pkg::res_word_t want;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      foreach (bin_model[b]) bin_model[b] = '0;
      tol_model = hvt_pkg::TOL_RESET;
      pix_took <= 1'b0;
      res_took <= 1'b0;
    end else begin
      if (cfg_wr_en) tol_model = cfg_wr_data;
      pix_took <= pix_valid && !pix_stall;
      res_took <= res_valid && !res_stall;

      if (pix_valid && !pix_stall) begin
        bin_idx = int'(pix_data.pixel) * BINS / hvt_pkg::GREY_LEVELS;
        // hold the count once it reaches the top
        if (bin_model[bin_idx] != hvt_pkg::COUNT_MAX)
          bin_model[bin_idx] = bin_model[bin_idx] + 1'b1;
        if (pix_data.last_pixel) begin
          thr_expected.push_back(predict_threshold());
          foreach (bin_model[b]) bin_model[b] = '0;
        end
      end

      if (res_valid && !res_stall) begin
        if (thr_expected.size() == 0) begin
          report_mismatch($sformatf("result threshold %0d found %0b with none pending",
                                    res_data.threshold, res_data.valley_found));
        end else begin
          want = thr_expected.pop_front();
          if (res_data.threshold !== want.threshold)
            report_mismatch($sformatf("threshold %0d, want %0d",
                                      res_data.threshold, want.threshold));
          if (res_data.valley_found !== want.valley_found)
            report_mismatch($sformatf("valley_found %0b, want %0b",
                                      res_data.valley_found, want.valley_found));
        end
      end
    end
  end

  // Pixel driver: pop items, wait the drawn gap, then hold the word until it
  // is taken. A repeated item stays valid with no gap between copies.
  always @(negedge clk) begin : pixel_driver
    logic               v;
    hvt_pkg::pix_word_t d;
    v = pix_valid;
    d = pix_data;
    if (rst) begin
      v = 1'b0;
      d = '0;
    end else begin
      if (pix_valid && pix_took) begin
        if (reps_left > 1) begin
          reps_left--;
        end else begin
          v       = 1'b0;
          driving = 1'b0;
        end
      end
      if (!v) begin
        if (!driving && pix_pending.size() > 0) begin
          cur_item  = pix_pending.pop_front();
          reps_left = cur_item.reps;
          gap_left  = quiet ? 0 : $urandom_range(0, 10);
          driving   = 1'b1;
        end
        if (driving) begin
          if (gap_left == 0) begin
            v = 1'b1;
            d = cur_item.word;
          end else begin
            gap_left--;
          end
        end
      end
    end
    // one assignment per signal per step
    pix_valid <= v;
    pix_data  <= d;
  end

  // Result receiver: stall each result for a drawn number of cycles, and run
  // one long hold-off on request so the block backs up into the pixel side.
  always @(negedge clk) begin : result_receiver
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (res_took) stall_left = quiet ? 0 : $urandom_range(0, 10);
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (res_valid && stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic queue_pixel(input int value, input bit last, input int reps);
    pix_item_t it;
    it.word.pixel      = hvt_pkg::PIX_W'(value);
    it.word.last_pixel = last;
    it.reps            = 24'(reps);
    pix_pending.push_back(it);
  endtask

  // Two mirrored hills of heights 1, 2, 4, 2, 1 centered on the given bins.
  task automatic queue_hills(input int left, input int right);
    for (int side = 0; side < 2; side++)
      for (int off = -2; off <= 2; off++)
        for (int k = 0; k < (4 >> (off < 0 ? -off : off)); k++)
          queue_pixel(((side == 1 ? right : left) + off) * BIN_W + k,
                      side == 1 && off == 2 && k == 0, 1);
  endtask

  // One random image of n pixels: mostly two hills, some single hills, some
  // flat noise, with the odd stray pixel anywhere.
  task automatic queue_image(input int n);
    int kind;
    int c0;
    int c1;
    int spread;
    int b;
    kind   = $urandom_range(0, 9);
    c0     = $urandom_range(1, BINS - 2);
    c1     = 1 + (c0 - 1 + int'($urandom_range(3, BINS - 5))) % (BINS - 2);
    spread = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      if (kind >= 8) begin
        b = $urandom_range(0, BINS - 1);
      end else begin
        b = ((kind < 6 && $urandom_range(0, 1) == 1) ? c1 : c0)
            + int'($urandom_range(0, spread)) - int'($urandom_range(0, spread));
        if ($urandom_range(0, 15) == 0) b = $urandom_range(0, BINS - 1);
        if (b < 0) b = 0;
        if (b > BINS - 1) b = BINS - 1;
      end
      queue_pixel(b * BIN_W + int'($urandom_range(0, BIN_W - 1)), k == n - 1, 1);
    end
  endtask

  // Pause the sender until every queued pixel is in and every result is out.
  task automatic wait_results();
    while (pix_pending.size() != 0 || driving || thr_expected.size() != 0) @(posedge clk);
  endtask

  // Write the tolerance only once the block has gone quiet.
  task automatic set_tolerance(input logic [hvt_pkg::TOL_W-1:0] value);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    int phase;
    int phase_items;
    int random_items;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: lone darkest and brightest pixels leave fewer than two peaks.
    queue_pixel(0, 1'b1, 1);
    queue_pixel(hvt_pkg::GREY_LEVELS - 1, 1'b1, 1);
    // two hills at the reset tolerance, valley between them
    queue_hills(6, 22);
    // zero tolerance: nothing counts as flat
    set_tolerance('0);
    queue_hills(6, 22);
    // widest tolerance, with a back-to-back run on one bin
    set_tolerance(TOL_MAX);
    queue_pixel(100, 1'b0, RUN_REPS);
    queue_hills(4, 24);

    // Random phases, each under its own tolerance.
    phase        = 0;
    random_items = 0;
    while (random_items < ITEM_TARGET) begin
      case (phase % 6)
        0: set_tolerance(hvt_pkg::TOL_RESET);
        1: set_tolerance(hvt_pkg::TOL_W'(1));
        2: set_tolerance(hvt_pkg::TOL_W'($urandom_range(2, 40)));
        3: set_tolerance(TOL_MAX);
        4: set_tolerance(hvt_pkg::TOL_W'($urandom_range(0, (1 << hvt_pkg::TOL_W) - 1)));
        default: set_tolerance(hvt_pkg::TOL_W'($urandom_range(2, 8)));
      endcase
      quiet = (phase % 6 == 2);
      // back up the result side while a burst of images is offered
      if (phase == 4) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && random_items < ITEM_TARGET) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 30);
        queue_image(n);
        phase_items  += n;
        random_items += n;
      end
      phase++;
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hvt_pkg.sv
hdl/hvt_alu.sv
hdl/hvt_hist.sv
hdl/hvt_seq.sv
hdl/histogram_valley_threshold.sv
hdl/hvt_chk.sv
bench/tb.sv
